### sv/fevd_pkg.sv
// ----------------------------------------------------------------------------
// fevd_pkg
// Shared widths, register indexes, reset values and stage structs for the
// frame energy voice detector.
// ----------------------------------------------------------------------------
package fevd_pkg;

  localparam int unsigned SampleW  = 16;
  localparam int unsigned SqW      = 31;
  localparam int unsigned EnergyW  = 43;
  localparam int unsigned ThrW     = 30;
  localparam int unsigned SilW     = 24;
  localparam int unsigned PreW     = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 30;

  localparam logic [ThrW-1:0] ThrReset = 30'd107374;
  localparam logic [SilW-1:0] SilReset = 24'd8000;
  localparam logic [PreW-1:0] PreReset = 16'd3200;

  typedef enum logic [CfgIdxW-1:0] {
    CfgThreshold    = 2'd0,
    CfgSilenceLimit = 2'd1,
    CfgPrerollLimit = 2'd2
  } cfg_idx_e;

  // One slot of the pipeline: occupied, and whether it carries a take request
  typedef struct packed {
    logic valid;
    logic take;
  } fevd_tok_t;

  typedef struct packed {
    logic            speech_active;
    logic            frame_voiced;
    logic            speech_onset;
    logic [PreW-1:0] preroll_count;
    logic            flush_ready;
  } fevd_res_t;

endpackage

### sv/fevd_accum.sv
// ----------------------------------------------------------------------------
// fevd_accum
// Squares each sample, then accumulates energy and length of the open frame
// and hands the totals on when the frame closes.
// ----------------------------------------------------------------------------
module fevd_accum
  import fevd_pkg::*;
#(
  parameter int unsigned MaxFrame = 4096,
  localparam int unsigned LenW    = $clog2(MaxFrame + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  fevd_tok_t                 tok_i,
  input  logic signed [SampleW-1:0] sample_i,
  input  logic                      frame_end_i,
  output fevd_tok_t                 tok_o,
  output logic [EnergyW-1:0]        energy_o,
  output logic [LenW-1:0]           len_o
);

  logic signed [2*SampleW-1:0] prod;
  logic [SqW-1:0]              sq_q;
  fevd_tok_t                   sq_tok_q;
  logic                        sq_fend_q;

  logic [EnergyW-1:0] esum_q;
  logic [LenW-1:0]    len_q;
  logic [EnergyW:0]   esum_ext;
  logic [EnergyW-1:0] esum_new;
  logic [LenW-1:0]    len_new;
  logic               close;

  always_comb begin
    prod     = sample_i * sample_i;
    esum_ext = {1'b0, esum_q} + {{(EnergyW + 1 - SqW){1'b0}}, sq_q};
    esum_new = esum_ext[EnergyW] ? {EnergyW{1'b1}} : esum_ext[EnergyW-1:0];
    len_new  = len_q + 1'b1;
    close    = sq_fend_q || (len_new == LenW'(MaxFrame));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_tok_q <= '0;
      tok_o    <= '0;
      esum_q   <= '0;
      len_q    <= '0;
    end else if (en_i) begin
      sq_tok_q <= tok_i;
      // pass on a take or a closing sample, drop everything else
      tok_o    <= (sq_tok_q.valid && (sq_tok_q.take || close)) ? sq_tok_q : '0;
      if (sq_tok_q.valid) begin
        if (sq_tok_q.take || close) begin
          // clear the frame: drop it on a take, restart it after a closing sample
          esum_q <= '0;
          len_q  <= '0;
        end else begin
          esum_q <= esum_new;
          len_q  <= len_new;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q      <= prod[SqW-1:0];
      sq_fend_q <= frame_end_i;
      energy_o  <= esum_new;
      len_o     <= len_new;
    end
  end

endmodule

### sv/fevd_decide.sv
// ----------------------------------------------------------------------------
// fevd_decide
// Forms the frame threshold, compares it with the frame energy and updates
// the speech, silence and pre-roll state for each closed frame.
// ----------------------------------------------------------------------------
module fevd_decide
  import fevd_pkg::*;
#(
  parameter int unsigned MaxFrame = 4096,
  localparam int unsigned LenW    = $clog2(MaxFrame + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  fevd_tok_t          tok_i,
  input  logic [EnergyW-1:0] energy_i,
  input  logic [LenW-1:0]    len_i,
  input  logic [ThrW-1:0]    threshold_i,
  input  logic [SilW-1:0]    silence_limit_i,
  input  logic [PreW-1:0]    preroll_limit_i,
  output logic               res_valid_o,
  output fevd_res_t          res_o
);

  localparam int unsigned ProdW = ThrW + LenW;
  localparam int unsigned CmpW  = (ProdW > EnergyW) ? ProdW : EnergyW;

  // threshold product stage
  fevd_tok_t          p_tok_q;
  logic [ProdW-1:0]   p_prod_q;
  logic [EnergyW-1:0] p_energy_q;
  logic [LenW-1:0]    p_len_q;

  // compare stage
  fevd_tok_t       c_tok_q;
  logic            c_voiced_q;
  logic [LenW-1:0] c_len_q;

  // speech state
  logic            active_q, active_d;
  logic [SilW-1:0] silence_q, silence_d;
  logic [PreW-1:0] preroll_q, preroll_d;

  logic [SilW:0]   sil_sum;
  logic [PreW:0]   pre_sum;
  logic [PreW-1:0] pre_capped;

  always_comb begin
    sil_sum    = {1'b0, silence_q} + (SilW + 1)'(c_len_q);
    pre_sum    = {1'b0, preroll_q} + (PreW + 1)'(c_len_q);
    pre_capped = (pre_sum > {1'b0, preroll_limit_i}) ? preroll_limit_i
                                                      : pre_sum[PreW-1:0];
    active_d  = active_q;
    silence_d = silence_q;
    preroll_d = preroll_q;
    res_o     = '0;
    if (c_voiced_q) begin
      // onset reports and empties the pre-roll
      res_o.speech_onset  = !active_q;
      res_o.preroll_count = active_q ? '0 : preroll_q;
      preroll_d           = active_q ? preroll_q : '0;
      active_d            = 1'b1;
      silence_d           = '0;
    end else if (active_q) begin
      silence_d = sil_sum[SilW] ? {SilW{1'b1}} : sil_sum[SilW-1:0];
    end else begin
      preroll_d = pre_capped;
    end
    res_o.speech_active = active_d;
    res_o.frame_voiced  = c_voiced_q;
    res_o.flush_ready   = active_d && (silence_d >= silence_limit_i);
    res_valid_o         = c_tok_q.valid && !c_tok_q.take;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_tok_q   <= '0;
      c_tok_q   <= '0;
      active_q  <= 1'b0;
      silence_q <= '0;
      preroll_q <= '0;
    end else if (en_i) begin
      p_tok_q <= tok_i;
      c_tok_q <= p_tok_q;
      if (c_tok_q.valid) begin
        if (c_tok_q.take) begin
          active_q  <= 1'b0;
          silence_q <= '0;
          preroll_q <= '0;
        end else begin
          active_q  <= active_d;
          silence_q <= silence_d;
          preroll_q <= preroll_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_prod_q   <= threshold_i * len_i;
      p_energy_q <= energy_i;
      p_len_q    <= len_i;
      c_voiced_q <= CmpW'(p_energy_q) > CmpW'(p_prod_q);
      c_len_q    <= p_len_q;
    end
  end

endmodule

### sv/frame_energy_voice_detector.sv
// ----------------------------------------------------------------------------
// frame_energy_voice_detector
// Frame energy speech detector: one result per closed frame, none for other
// samples or take requests.
// ----------------------------------------------------------------------------
// Path: input register, square, accumulate, product, compare, output register.
// Throughput: one request per cycle; the pipeline stalls only when the output
// register and its skid slot both hold results.
// Reset: detector state and all slots clear; registers return to defaults.
// ----------------------------------------------------------------------------
module frame_energy_voice_detector
  import fevd_pkg::*;
#(
  parameter int unsigned MAX_FRAME_SAMPLES = 4096
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      req_type_i,
  input  logic signed [SampleW-1:0] sample_i,
  input  logic                      frame_end_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      speech_active_o,
  output logic                      frame_voiced_o,
  output logic                      speech_onset_o,
  output logic [PreW-1:0]           preroll_count_o,
  output logic                      flush_ready_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CfgIdxW-1:0]        cfg_index_i,
  input  logic [CfgDataW-1:0]       cfg_data_i
);

  localparam int unsigned LenW = $clog2(MAX_FRAME_SAMPLES + 1);

  logic [ThrW-1:0] thr_q;
  logic [SilW-1:0] sil_lim_q;
  logic [PreW-1:0] pre_lim_q;

  logic                      en;
  fevd_tok_t                 a_tok_q;
  logic signed [SampleW-1:0] a_sample_q;
  logic                      a_fend_q;

  fevd_tok_t          acc_tok;
  logic [EnergyW-1:0] acc_energy;
  logic [LenW-1:0]    acc_len;

  logic      res_valid;
  fevd_res_t res;
  logic      res_fire;

  logic      out_v_q, skid_v_q;
  fevd_res_t out_q, skid_q;

  assign cfg_ready_o = 1'b1;
  assign en          = !skid_v_q;
  assign in_ready_o  = en;
  assign res_fire    = en && res_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= ThrReset;
      sil_lim_q <= SilReset;
      pre_lim_q <= PreReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgThreshold:    thr_q     <= cfg_data_i[ThrW-1:0];
        CfgSilenceLimit: sil_lim_q <= cfg_data_i[SilW-1:0];
        CfgPrerollLimit: pre_lim_q <= cfg_data_i[PreW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_tok_q <= '0;
    end else if (en) begin
      a_tok_q.valid <= in_valid_i;
      a_tok_q.take  <= req_type_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_sample_q <= sample_i;
      a_fend_q   <= frame_end_i;
    end
  end

  fevd_accum #(
    .MaxFrame (MAX_FRAME_SAMPLES)
  ) u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .tok_i       (a_tok_q),
    .sample_i    (a_sample_q),
    .frame_end_i (a_fend_q),
    .tok_o       (acc_tok),
    .energy_o    (acc_energy),
    .len_o       (acc_len)
  );

  fevd_decide #(
    .MaxFrame (MAX_FRAME_SAMPLES)
  ) u_decide (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (en),
    .tok_i           (acc_tok),
    .energy_i        (acc_energy),
    .len_i           (acc_len),
    .threshold_i     (thr_q),
    .silence_limit_i (sil_lim_q),
    .preroll_limit_i (pre_lim_q),
    .res_valid_o     (res_valid),
    .res_o           (res)
  );

  // Output register with one skid slot behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (out_v_q && out_ready_i) begin
        if (skid_v_q) begin
          skid_v_q <= 1'b0;
        end else begin
          out_v_q <= res_fire;
        end
      end else if (!out_v_q) begin
        out_v_q <= res_fire;
      end else if (res_fire) begin
        skid_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_v_q && out_ready_i) begin
      if (skid_v_q) begin
        out_q <= skid_q;
      end else if (res_fire) begin
        out_q <= res;
      end
    end else if (!out_v_q) begin
      if (res_fire) begin
        out_q <= res;
      end
    end else if (res_fire) begin
      skid_q <= res;
    end
  end

  assign out_valid_o     = out_v_q;
  assign speech_active_o = out_q.speech_active;
  assign frame_voiced_o  = out_q.frame_voiced;
  assign speech_onset_o  = out_q.speech_onset;
  assign preroll_count_o = out_q.preroll_count;
  assign flush_ready_o   = out_q.flush_ready;

endmodule

### tb/fevd_checker.sv
// ----------------------------------------------------------------------------
// fevd_checker
// Watches the request, result and register channels of the voice detector,
// predicts each frame verdict and compares it with what the block returns.
// ----------------------------------------------------------------------------
module fevd_checker
  import fevd_pkg::*;
#(
  parameter int unsigned MAX_FRAME_SAMPLES = 4096
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic                      req_type_i,
  input  logic signed [SampleW-1:0] sample_i,
  input  logic                      frame_end_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic                      speech_active_i,
  input  logic                      frame_voiced_i,
  input  logic                      speech_onset_i,
  input  logic [PreW-1:0]           preroll_count_i,
  input  logic                      flush_ready_i,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_i,
  input  logic [CfgIdxW-1:0]        cfg_index_i,
  input  logic [CfgDataW-1:0]       cfg_data_i,
  output int unsigned               pending_o,
  output int unsigned               fail_count_o
);

  localparam int unsigned LenW = $clog2(MAX_FRAME_SAMPLES + 1);
  localparam logic [63:0] EnergyMax = (64'd1 << EnergyW) - 64'd1;
  localparam logic [63:0] SilenceMax = (64'd1 << SilW) - 64'd1;

  logic [ThrW-1:0]    thr_q;
  logic [SilW-1:0]    sil_limit_q;
  logic [PreW-1:0]    pre_limit_q;

  logic [EnergyW-1:0] energy_q;
  logic [LenW-1:0]    flen_q;
  logic               active_q;
  logic [SilW-1:0]    silence_q;
  logic [PreW-1:0]    fill_q;

  fevd_res_t verdict_q[$];

  task automatic clear_detector();
    energy_q  = '0;
    flen_q    = '0;
    active_q  = 1'b0;
    silence_q = '0;
    fill_q    = '0;
  endtask

  // Fold one request into the detector state; queue a verdict when a frame closes
  task automatic absorb_request(input logic take, input logic signed [SampleW-1:0] smp,
                                input logic close_frame);
    int          mag;
    logic [63:0] acc;
    logic [63:0] bar;
    logic        voiced;
    fevd_res_t   verdict;
    if (take) begin
      clear_detector();
      return;
    end
    mag = (smp < 0) ? -int'(smp) : int'(smp);
    acc = 64'(energy_q) + 64'(mag) * 64'(mag);
    if (acc > EnergyMax) acc = EnergyMax;
    energy_q = acc[EnergyW-1:0];
    flen_q   = flen_q + 1'b1;
    if (!close_frame && flen_q < LenW'(MAX_FRAME_SAMPLES)) return;

    bar    = 64'(thr_q) * 64'(flen_q);
    voiced = 64'(energy_q) > bar;
    verdict = '0;
    if (voiced) begin
      if (!active_q) begin
        verdict.speech_onset  = 1'b1;
        verdict.preroll_count = fill_q;
        fill_q = '0;
      end
      active_q  = 1'b1;
      silence_q = '0;
    end else if (active_q) begin
      acc = 64'(silence_q) + 64'(flen_q);
      if (acc > SilenceMax) acc = SilenceMax;
      silence_q = acc[SilW-1:0];
    end else begin
      acc = 64'(fill_q) + 64'(flen_q);
      if (acc > 64'(pre_limit_q)) acc = 64'(pre_limit_q);
      fill_q = acc[PreW-1:0];
    end
    energy_q = '0;
    flen_q   = '0;

    verdict.speech_active = active_q;
    verdict.frame_voiced  = voiced;
    verdict.flush_ready   = active_q && (silence_q >= sil_limit_q);
    verdict_q.insert(verdict_q.size(), verdict);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    fevd_res_t want;
    fevd_res_t got;
    if (!rst_ni) begin
      thr_q       = ThrReset;
      sil_limit_q = SilReset;
      pre_limit_q = PreReset;
      clear_detector();
      verdict_q.delete();
      pending_o    = 0;
      fail_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgThreshold:    thr_q       = cfg_data_i[ThrW-1:0];
          CfgSilenceLimit: sil_limit_q = cfg_data_i[SilW-1:0];
          CfgPrerollLimit: pre_limit_q = cfg_data_i[PreW-1:0];
          default: ;  // drop writes to unused indexes
        endcase
      end

      if (in_valid_i && in_ready_i) absorb_request(req_type_i, sample_i, frame_end_i);

      if (out_valid_i && out_ready_i) begin
        got.speech_active = speech_active_i;
        got.frame_voiced  = frame_voiced_i;
        got.speech_onset  = speech_onset_i;
        got.preroll_count = preroll_count_i;
        got.flush_ready   = flush_ready_i;
        if (verdict_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%0t: frame result with no frame closed: active=%0b voiced=%0b",
                     $realtime, got.speech_active, got.frame_voiced);
        end else begin
          want = verdict_q[0];
          verdict_q.delete(0);
          if (got.speech_active !== want.speech_active ||
              got.frame_voiced  !== want.frame_voiced  ||
              got.speech_onset  !== want.speech_onset  ||
              got.preroll_count !== want.preroll_count ||
              got.flush_ready   !== want.flush_ready) begin
            fail_count_o++;
            if (fail_count_o <= 10) begin
              $display("%0t: verdict mismatch, expected active=%0b voiced=%0b onset=%0b",
                       $realtime, want.speech_active, want.frame_voiced, want.speech_onset);
              $display("  preroll=%0d flush=%0b; got active=%0b voiced=%0b onset=%0b",
                       want.preroll_count, want.flush_ready, got.speech_active,
                       got.frame_voiced, got.speech_onset);
              $display("  preroll=%0d flush=%0b", got.preroll_count, got.flush_ready);
            end
          end
        end
      end
      pending_o = verdict_q.size();
    end
  end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives the voice detector with directed frames and randomised frame streams
// under several register settings, with random gaps on both channels; the
// checker beside the block predicts every frame verdict.
// ----------------------------------------------------------------------------
module tb;
  import fevd_pkg::*;

  localparam int unsigned MaxFrame   = 4096;
  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned DrainWait  = 12;
  localparam int unsigned RandItems  = 850;

  localparam logic ReqSample = 1'b0;
  localparam logic ReqTake   = 1'b1;
  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;

  localparam logic [ThrW-1:0] ThrMax = '1;
  localparam logic [SilW-1:0] SilMax = '1;
  localparam logic [PreW-1:0] PreMax = '1;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic                      req_type;
  logic signed [SampleW-1:0] sample_val;
  logic                      frame_end;
  logic                      out_valid;
  logic                      out_ready;
  logic                      speech_active;
  logic                      frame_voiced;
  logic                      speech_onset;
  logic [PreW-1:0]           preroll_count;
  logic                      flush_ready;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CfgIdxW-1:0]        cfg_index;
  logic [CfgDataW-1:0]       cfg_data;

  int unsigned pending;
  int unsigned fail_count;
  bit          calm;
  int          cur_thr;

  frame_energy_voice_detector #(
    .MAX_FRAME_SAMPLES(MaxFrame)
  ) u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .req_type_i     (req_type),
    .sample_i       (sample_val),
    .frame_end_i    (frame_end),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .speech_active_o(speech_active),
    .frame_voiced_o (frame_voiced),
    .speech_onset_o (speech_onset),
    .preroll_count_o(preroll_count),
    .flush_ready_o  (flush_ready),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  fevd_checker #(
    .MAX_FRAME_SAMPLES(MaxFrame)
  ) u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .req_type_i     (req_type),
    .sample_i       (sample_val),
    .frame_end_i    (frame_end),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .speech_active_i(speech_active),
    .frame_voiced_i (frame_voiced),
    .speech_onset_i (speech_onset),
    .preroll_count_i(preroll_count),
    .flush_ready_i  (flush_ready),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .pending_o      (pending),
    .fail_count_o   (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  // Result side: hold ready low for a random number of cycles per result
  initial begin
    int unsigned stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Enter at a falling edge, leave at the falling edge after acceptance
  task automatic push_req(input logic kind, input logic signed [SampleW-1:0] smp,
                          input logic close_frame);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= kind;
    sample_val <= smp;
    frame_end  <= close_frame;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_frame(input int len, input int amp, input bit closed);
    int s;
    for (int i = 0; i < len; i++) begin
      s = int'($urandom_range(0, 2 * amp)) - amp;
      push_req(ReqSample, SampleW'(s), closed && (i == len - 1));
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DrainWait) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Registers change only once the block has drained; upper data bits are junk
  task automatic program_regs(input logic [ThrW-1:0] thr, input logic [SilW-1:0] sil,
                              input logic [PreW-1:0] pre);
    wait_idle();
    write_reg(CfgThreshold, thr);
    write_reg(CfgSilenceLimit, {6'($urandom()), sil});
    write_reg(CfgPrerollLimit, {14'($urandom()), pre});
    write_reg(CfgSpare, CfgDataW'($urandom()));
    cfg_valid <= 1'b0;
    cur_thr = int'(thr);
  endtask

  initial begin
    int unsigned fed;
    int unsigned pick;
    int          len;
    int          amp;
    int          amp_ref;
    logic [ThrW-1:0] thr;
    logic [SilW-1:0] sil;
    logic [PreW-1:0] pre;

    rst_n      = 1'b0;
    in_valid   = 1'b0;
    req_type   = ReqSample;
    sample_val = '0;
    frame_end  = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = CfgThreshold;
    cfg_data   = '0;
    calm       = 1'b0;
    cur_thr    = int'(ThrReset);
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Default registers: onset with pre-roll, quiet speech, takes while idle,
    // in speech and mid-frame
    push_req(ReqTake, 16'sh7FFF, 1'b1);
    push_req(ReqSample, 16'sh0000, 1'b1);
    push_req(ReqSample, 16'sh7FFF, 1'b1);
    push_req(ReqSample, -16'sh8000, 1'b1);
    push_req(ReqSample, 16'sh0001, 1'b0);
    push_req(ReqSample, -16'sh0001, 1'b0);
    push_req(ReqSample, 16'sh0000, 1'b1);
    push_req(ReqTake, 16'sh0000, 1'b0);
    push_req(ReqSample, 16'sh0064, 1'b0);
    push_req(ReqSample, -16'sh00C8, 1'b0);
    push_req(ReqTake, -16'sh0001, 1'b0);
    push_req(ReqSample, 16'sh0000, 1'b1);

    // Zero threshold and zero silence limit, pre-roll capped at two
    program_regs('0, '0, 16'd2);
    send_frame(3, 0, 1'b1);
    push_req(ReqSample, 16'sh0001, 1'b1);
    push_req(ReqSample, 16'sh0000, 1'b1);

    // Largest settings and an overlong frame of full-scale negative samples
    program_regs(ThrMax, SilMax, PreMax);
    calm = 1'b1;
    push_req(ReqTake, 16'sh0000, 1'b1);
    repeat (MaxFrame) push_req(ReqSample, -16'sh8000, 1'b0);
    push_req(ReqSample, 16'sh7FFF, 1'b1);
    calm = 1'b0;

    // Fill pre-roll, then lower its limit below the fill
    push_req(ReqTake, 16'sh0000, 1'b0);
    send_frame(10, 0, 1'b1);
    program_regs(30'd10, SilReset, 16'd4);
    push_req(ReqSample, 16'sh0000, 1'b1);
    push_req(ReqSample, 16'sh0007, 1'b1);

    fed = 0;
    while (fed < RandItems) begin
      case ($urandom_range(0, 5))
        0:       thr = '0;
        1:       thr = ThrMax;
        2:       thr = ThrReset;
        default: thr = ThrW'($urandom() >> $urandom_range(2, 31));
      endcase
      case ($urandom_range(0, 4))
        0:       sil = '0;
        1:       sil = SilMax;
        default: sil = SilW'($urandom_range(1, 60));
      endcase
      case ($urandom_range(0, 4))
        0:       pre = '0;
        1:       pre = PreMax;
        default: pre = PreW'($urandom_range(1, 40));
      endcase
      program_regs(thr, sil, pre);
      calm = ($urandom_range(0, 3) == 0);

      // Amplitude whose square sits at the threshold
      amp_ref = 0;
      while (amp_ref < 32767 && amp_ref * amp_ref < cur_thr) amp_ref++;

      repeat (30) begin
        pick = $urandom_range(0, 99);
        len  = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 80) : $urandom_range(1, 16);
        case ($urandom_range(0, 2))
          0:       amp = $urandom_range(0, 3);
          1:       amp = 32767;
          default: amp = amp_ref + $urandom_range(0, amp_ref + 2);
        endcase
        if (amp > 32767) amp = 32767;
        if (pick < 5) begin
          push_req(ReqTake, SampleW'($urandom()), 1'($urandom()));
          fed += 1;
        end else if (pick < 12) begin
          push_req(1'($urandom()), SampleW'($urandom()), 1'($urandom()));
          fed += 1;
        end else if (pick < 17) begin
          // broken frame: never closed, thrown away by a take
          send_frame(len, amp, 1'b0);
          push_req(ReqTake, SampleW'($urandom()), 1'($urandom()));
          fed += len + 1;
        end else begin
          send_frame(len, amp, 1'b1);
          fed += len;
        end
      end
    end
    calm = 1'b0;

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DrainWait) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### frame_energy_voice_detector.f
sv/fevd_pkg.sv
sv/fevd_accum.sv
sv/fevd_decide.sv
sv/frame_energy_voice_detector.sv
tb/fevd_checker.sv
tb/tb.sv
